// ===== rtl/sao_pkg.sv =====
// Shared types and constants for the straight-alpha source-over blender.
// Used by sao_front, sao_cell and straight_alpha_over_blend; no dependencies.
package sao_pkg;

  localparam logic [7:0] OpacityReset = 8'd255;
  localparam int unsigned RemW = 27;
  localparam int unsigned DenW = 17;
  localparam int unsigned QuoW = 9;
  localparam int unsigned Lanes = 3;
  localparam logic [15:0] Recip255 = 16'h8081;

  typedef struct packed {
    logic [Lanes-1:0][RemW-1:0] rem;
    logic [DenW-1:0]            den;
    logic [Lanes-1:0][QuoW-1:0] quo;
    logic [7:0]                 alpha;
    logic                       zero;
  } div_word_t;

endpackage

// ===== rtl/sao_front.sv =====
// Front pipeline of the blender: effective alpha, alpha numerator and color numerators.
// Depends on sao_pkg. Feeds the divider cell chain with a sao_pkg::div_word_t.
module sao_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           layer_opacity,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic [31:0]          src,
  input  logic [31:0]          dst,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output sao_pkg::div_word_t   dn_word
);

  logic [4:0] v;
  logic [4:0] rdy;

  logic [31:0] s1_src, s1_dst;
  logic [15:0] s1_prod;
  logic [31:0] s2_src, s2_dst;
  logic [7:0]  s2_eff;
  logic [15:0] s3_an;
  logic [2:0][15:0] s3_sc, s3_dc;
  logic [7:0]  s3_inv;
  logic [2:0][24:0] s4_num;
  logic [15:0] s4_an;
  logic [7:0]  s4_alpha;

  logic [32:0] eff_prod;
  logic [32:0] alpha_prod;
  logic [7:0]  inv2;

  assign rdy[4] = !v[4] || dn_ready;
  assign rdy[3] = !v[3] || rdy[4];
  assign rdy[2] = !v[2] || rdy[3];
  assign rdy[1] = !v[1] || rdy[2];
  assign rdy[0] = !v[0] || rdy[1];
  assign up_ready = rdy[0];
  assign dn_valid = v[4];

  assign eff_prod = 33'((17'(s1_prod) + 17'd127) * 17'(sao_pkg::Recip255));
  assign inv2 = 8'd255 - s2_eff;
  assign alpha_prod = 33'((17'(s3_an) + 17'd127) * 17'(sao_pkg::Recip255));

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= up_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
      if (rdy[4]) v[4] <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_src  <= src;
      s1_dst  <= dst;
      s1_prod <= 16'(src[7:0] * layer_opacity);
    end
    if (rdy[1]) begin
      s2_src <= s1_src;
      s2_dst <= s1_dst;
      s2_eff <= eff_prod[30:23];
    end
    if (rdy[2]) begin
      s3_an  <= 16'(s2_eff * 16'd255) + 16'(s2_dst[7:0] * inv2);
      s3_inv <= inv2;
      for (int i = 0; i < 3; i++) begin
        s3_sc[i] <= 16'(s2_src[8*i+8 +: 8] * s2_eff);
        s3_dc[i] <= 16'(s2_dst[8*i+8 +: 8] * s2_dst[7:0]);
      end
    end
    if (rdy[3]) begin
      s4_an    <= s3_an;
      s4_alpha <= alpha_prod[30:23];
      for (int i = 0; i < 3; i++) begin
        s4_num[i] <= 25'(s3_sc[i] * 24'd255) + 25'(s3_dc[i] * s3_inv);
      end
    end
    if (rdy[4]) begin
      dn_word.den   <= {s4_an, 1'b0};
      dn_word.alpha <= s4_alpha;
      dn_word.zero  <= (s4_an == 16'd0);
      dn_word.quo   <= '0;
      for (int i = 0; i < 3; i++) begin
        dn_word.rem[i] <= {1'b0, s4_num[i], 1'b0} + 27'(s4_an);
      end
    end
  end

endmodule

// ===== rtl/sao_cell.sv =====
// One restoring-division cell: decides quotient bit BIT for all three color lanes.
// Depends on sao_pkg; cells are chained in straight_alpha_over_blend.
module sao_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  sao_pkg::div_word_t   up_word,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output sao_pkg::div_word_t   dn_word
);

  sao_pkg::div_word_t nxt;
  logic [sao_pkg::RemW-1:0] trial;

  assign up_ready = !dn_valid || dn_ready;
  assign trial = sao_pkg::RemW'(up_word.den) << BIT;

  always_comb begin
    nxt = up_word;
    for (int i = 0; i < 3; i++) begin
      if (up_word.rem[i] >= trial) begin
        nxt.rem[i] = up_word.rem[i] - trial;
        nxt.quo[i][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_word <= nxt;
    end
  end

endmodule

// ===== rtl/straight_alpha_over_blend.sv =====
// Top level of the straight-alpha source-over blender.
// Depends on sao_pkg, sao_front and sao_cell.
//
// Usage: a word on the input channel (in_valid/in_ready) is one pair of
// RGBA8888 pixels, source_pixel and backdrop_pixel. Each word yields one
// blended_pixel word on the output channel (out_valid/out_ready), in order.
// The layer opacity is written through the cfg channel (cfg_valid/cfg_ready,
// cfg_data); cfg_ready is always high, and the value is meant to change only
// while the block is idle.
// Throughput is one word per cycle while the receiver takes every word. Five
// front stages compute the effective alpha and the numerators, then nine
// chained divider cells each settle one quotient bit for the three colors;
// the last cell is the output register.
// Reset clears all valid flags and sets the opacity to fully opaque.
// When the receiver stalls, words collect in the empty stages behind the
// output, and in_ready falls only once every stage holds a word.
module straight_alpha_over_blend (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] source_pixel,
  input  logic [31:0] backdrop_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] blended_pixel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int unsigned NCells = sao_pkg::QuoW;

  logic [7:0] layer_opacity;
  logic [NCells:0] v;
  logic [NCells:0] rdy;
  sao_pkg::div_word_t w [NCells+1];
  sao_pkg::div_word_t last;
  logic [2:0][7:0] chan;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_opacity <= sao_pkg::OpacityReset;
    end else if (cfg_valid) begin
      layer_opacity <= cfg_data;
    end
  end

  sao_front u_front (
    .clk, .rst, .layer_opacity,
    .up_valid(in_valid), .up_ready(in_ready),
    .src(source_pixel), .dst(backdrop_pixel),
    .dn_valid(v[0]), .dn_ready(rdy[0]), .dn_word(w[0])
  );

  for (genvar k = 0; k < NCells; k++) begin : g_cell
    sao_cell #(.BIT(NCells-1-k)) u_cell (
      .clk, .rst,
      .up_valid(v[k]), .up_ready(rdy[k]), .up_word(w[k]),
      .dn_valid(v[k+1]), .dn_ready(rdy[k+1]), .dn_word(w[k+1])
    );
  end

  assign rdy[NCells] = out_ready;
  assign out_valid = v[NCells];
  assign last = w[NCells];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      chan[i] = last.quo[i][8] ? 8'd255 : last.quo[i][7:0];
    end
  end

  assign blended_pixel = last.zero ? 32'd0 : {chan[2], chan[1], chan[0], last.alpha};

endmodule

// ===== rtl/sao_checker.sv =====
// Port-level checks for straight_alpha_over_blend, bound to the top level.
// Depends only on the top level's ports.
module sao_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] blended_pixel,
  input logic        cfg_ready
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("output word dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(blended_pixel)) else $error("output word changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("output valid after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready && cfg_ready) else $error("empty block refuses input");

endmodule

bind straight_alpha_over_blend sao_checker u_sao_checker (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .blended_pixel, .cfg_ready
);

// ===== tb/testbench.sv =====
// Testbench for straight_alpha_over_blend: source-over blending of RGBA8888 pairs.
// Drives pixel pairs and opacity writes, predicts each blended word, and checks it.
// Depends on rtl/straight_alpha_over_blend.sv and its submodules.
`timescale 1ns / 100ps

module testbench;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] source_pixel;
  logic [31:0] backdrop_pixel;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] blended_pixel;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  logic [7:0]  opacity;
  logic [31:0] expected_pixels[$];
  int          failures;
  int          idle_cycles;
  bit          stall_enable;

  localparam int IdleLimit = 20000;
  localparam int Latency = 14;

  straight_alpha_over_blend i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .source_pixel(source_pixel),
    .backdrop_pixel(backdrop_pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .blended_pixel(blended_pixel),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      return 0;
    end else if (pick < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] blend_over(logic [31:0] src, logic [31:0] dst,
                                             logic [7:0] op);
    logic [31:0] eff_a;
    logic [31:0] dst_a;
    logic [31:0] alpha_num;
    logic [31:0] out_a;
    logic [63:0] num;
    logic [63:0] quo;
    logic [31:0] result;
    eff_a = (src[7:0] * op + 127) / 255;
    dst_a = dst[7:0];
    alpha_num = eff_a * 255 + dst_a * (255 - eff_a);
    result = '0;
    if (alpha_num != 0) begin
      out_a = (alpha_num + 127) / 255;
      result[7:0] = (out_a > 255) ? 8'd255 : out_a[7:0];
      for (int sh = 8; sh <= 24; sh += 8) begin
        num = 64'(src[sh +: 8]) * eff_a * 255
            + 64'(dst[sh +: 8]) * dst_a * (255 - eff_a);
        quo = (2 * num + alpha_num) / (2 * 64'(alpha_num));
        result[sh +: 8] = (quo > 255) ? 8'd255 : quo[7:0];
      end
    end
    return result;
  endfunction

  // A word stays valid into the next one when there is no gap between them.
  task automatic send_pair(logic [31:0] src, logic [31:0] dst);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    source_pixel <= src;
    backdrop_pixel <= dst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_pixels.push_back(blend_over(src, dst, opacity));
    @(negedge clk);
  endtask

  task automatic write_opacity(logic [7:0] value);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (Latency + 2) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    opacity = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (!stall_enable || $urandom_range(0, 99) < 60) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("blended_pixel: unexpected word %h", blended_pixel);
        failures++;
      end else begin
        want = expected_pixels.pop_front();
        if (blended_pixel !== want) begin
          $error("blended_pixel: expected %h, actual %h", want, blended_pixel);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic test_extremes();
    logic [31:0] corners[6];
    corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'h0000_00FF,
                32'h8040_2001, 32'h1234_56FE};
    foreach (corners[i]) begin
      foreach (corners[j]) begin
        if (j % 2 == i % 2) begin
          send_pair(corners[i], corners[j]);
        end
      end
    end
    send_pair(32'hAA55_AA00, 32'h55AA_5500);
    send_pair(32'h55AA_5580, 32'hAA55_AA7F);
  endtask

  task automatic test_transparent_layer();
    write_opacity(8'd0);
    send_pair(32'hFFFF_FFFF, 32'h1020_3040);
    send_pair(32'h0102_0304, 32'hFFFF_FF00);
    send_pair(32'hFFFF_FFFF, 32'hFEDC_BAFF);
  endtask

  task automatic test_random(int count);
    logic [31:0] src;
    logic [31:0] dst;
    for (int n = 0; n < count; n++) begin
      src = $urandom;
      dst = $urandom;
      case ($urandom_range(0, 7))
        0: src[7:0] = 8'd0;
        1: src[7:0] = 8'd255;
        2: dst[7:0] = 8'd0;
        3: dst[7:0] = 8'd255;
        default: ;
      endcase
      send_pair(src, dst);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    source_pixel = '0;
    backdrop_pixel = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    failures = 0;
    idle_cycles = 0;
    stall_enable = 1'b0;
    opacity = 8'd255;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_transparent_layer();
    stall_enable = 1'b1;
    write_opacity(8'd255);
    test_random(300);
    write_opacity(8'd1);
    test_random(120);
    write_opacity(8'd128);
    test_random(200);
    write_opacity(8'd0);
    test_random(60);
    write_opacity(8'($urandom_range(2, 254)));
    test_random(150);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sao_pkg.sv
rtl/sao_front.sv
rtl/sao_cell.sv
rtl/straight_alpha_over_blend.sv
rtl/sao_checker.sv
tb/testbench.sv
